@@ sv/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the voxel mesh node numbering block.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/vhmnn_pkg.sv @@
// ============================================================================
// vhmnn_pkg
// Types and fixed constants of the voxel hexahedral mesh node numbering block.
// ============================================================================
package vhmnn_pkg;

    // Node table depth. It is a power of two, so the node index wraps by
    // dropping its upper bits.
    localparam int NODE_DEPTH = 262144;

    // Field widths
    localparam int POS_W      = 6;
    localparam int MAT_W      = 8;
    localparam int CORNER_W   = 3;
    localparam int ID_W       = 18;
    localparam int COORD_W    = 38;
    localparam int SPC_W      = 32;
    localparam int GRID_W     = POS_W + 1;
    localparam int PROD_W     = GRID_W + SPC_W;
    localparam int PLANE_W    = 13;
    localparam int RAW_IDX_W  = 19;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Reset values
    localparam logic [POS_W-1:0]   MAX_DIM        = 6'd63;
    localparam logic [POS_W-1:0]   X_START_RESET  = 6'd0;
    localparam logic [POS_W-1:0]   X_COUNT_RESET  = 6'd63;
    localparam logic [SPC_W-1:0]   SPACING_RESET  = 32'h0001_0000;
    localparam logic [PLANE_W-1:0] PLANE_RESET    =
        PLANE_W'((int'(MAX_DIM) + 1) * (int'(MAX_DIM) + 1));

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_DIM_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_Z     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_X_START   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_X_COUNT   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SPACING_X = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPACING_Y = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPACING_Z = 3'd7;

    // Corner offsets of the hexahedral cell, one bit per corner number.
    localparam logic [7:0] OFF_X_MASK = 8'b0110_0110;
    localparam logic [7:0] OFF_Y_MASK = 8'b1100_1100;
    localparam logic [7:0] OFF_Z_MASK = 8'b1111_0000;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] dim_x;
        logic [POS_W-1:0] dim_y;
        logic [POS_W-1:0] dim_z;
        logic [POS_W-1:0] x_start;
        logic [POS_W-1:0] x_count;
        logic [SPC_W-1:0] spacing_x;
        logic [SPC_W-1:0] spacing_y;
        logic [SPC_W-1:0] spacing_z;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] x_start;
    } restart_t;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } node_entry_t;

    typedef struct packed {
        logic [RAW_IDX_W-1:0] raw_idx;
        logic [CORNER_W-1:0]  corner;
        logic [MAT_W-1:0]     material;
        logic [PROD_W-1:0]    prod_x;
        logic [PROD_W-1:0]    prod_y;
        logic [PROD_W-1:0]    prod_z;
    } corner_req_t;

    typedef struct packed {
        logic        valid;
        corner_req_t req;
    } issue_t;

endpackage

@@ sv/vhmnn_in_if.sv @@
// ============================================================================
// vhmnn_in_if
// Voxel input channel: one material byte per word.
// ============================================================================
interface vhmnn_in_if import vhmnn_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [MAT_W-1:0] voxel_material;

    modport source (output valid, output voxel_material, input ready);
    modport sink   (input valid, input voxel_material, output ready);

endinterface

@@ sv/vhmnn_out_if.sv @@
// ============================================================================
// vhmnn_out_if
// Corner output channel: one cell corner with its node id per word.
// ============================================================================
interface vhmnn_out_if import vhmnn_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [CORNER_W-1:0] corner;
    logic [ID_W-1:0]     node_id;
    logic                node_new;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  coord_z;
    logic [MAT_W-1:0]    cell_material;
    logic                cell_last;

    modport source (
        output valid, output corner, output node_id, output node_new,
        output coord_x, output coord_y, output coord_z,
        output cell_material, output cell_last,
        input ready
    );
    modport sink (
        input valid, input corner, input node_id, input node_new,
        input coord_x, input coord_y, input coord_z,
        input cell_material, input cell_last,
        output ready
    );

endinterface

@@ sv/vhmnn_cfg.sv @@
// ============================================================================
// vhmnn_cfg
// APB register file: grid dimensions, slab range and voxel spacing.
// ============================================================================
module vhmnn_cfg import vhmnn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg,
    output restart_t              restart
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr;
    logic [REG_IDX_W-1:0] idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // A write to x_start also rewinds the scan position.
    assign restart.valid   = wr && (idx == REG_X_START);
    assign restart.x_start = pwdata[POS_W-1:0];

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_DIM_X:     cfg_next.dim_x     = pwdata[POS_W-1:0];
                REG_DIM_Y:     cfg_next.dim_y     = pwdata[POS_W-1:0];
                REG_DIM_Z:     cfg_next.dim_z     = pwdata[POS_W-1:0];
                REG_X_START:   cfg_next.x_start   = pwdata[POS_W-1:0];
                REG_X_COUNT:   cfg_next.x_count   = pwdata[POS_W-1:0];
                REG_SPACING_X: cfg_next.spacing_x = pwdata[SPC_W-1:0];
                REG_SPACING_Y: cfg_next.spacing_y = pwdata[SPC_W-1:0];
                REG_SPACING_Z: cfg_next.spacing_z = pwdata[SPC_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux.
    always_comb
    begin
        case (idx)
            REG_DIM_X:     prdata = APB_DATA_W'(cfg_reg.dim_x);
            REG_DIM_Y:     prdata = APB_DATA_W'(cfg_reg.dim_y);
            REG_DIM_Z:     prdata = APB_DATA_W'(cfg_reg.dim_z);
            REG_X_START:   prdata = APB_DATA_W'(cfg_reg.x_start);
            REG_X_COUNT:   prdata = APB_DATA_W'(cfg_reg.x_count);
            REG_SPACING_X: prdata = cfg_reg.spacing_x;
            REG_SPACING_Y: prdata = cfg_reg.spacing_y;
            REG_SPACING_Z: prdata = cfg_reg.spacing_z;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_x     <= MAX_DIM;
            cfg_reg.dim_y     <= MAX_DIM;
            cfg_reg.dim_z     <= MAX_DIM;
            cfg_reg.x_start   <= X_START_RESET;
            cfg_reg.x_count   <= X_COUNT_RESET;
            cfg_reg.spacing_x <= SPACING_RESET;
            cfg_reg.spacing_y <= SPACING_RESET;
            cfg_reg.spacing_z <= SPACING_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ sv/vhmnn_node_table.sv @@
// ============================================================================
// vhmnn_node_table
// Node table memory: one write port, one read port with registered data,
// a clearing sweep after reset and forwarding of a write that lands on the
// entry being read in the same cycle.
// ============================================================================
`include "assert_macros.svh"

module vhmnn_node_table import vhmnn_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [$clog2(NODE_DEPTH)-1:0] rd_addr,
    output node_entry_t                   rd_data,
    input  logic                          wr_en,
    input  logic [$clog2(NODE_DEPTH)-1:0] wr_addr,
    input  node_entry_t                   wr_data,
    output logic                          clear_done
);

    localparam int IDX_W = $clog2(NODE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(NODE_DEPTH - 1);

    node_entry_t mem [NODE_DEPTH];

    logic             clearing_reg;
    logic             clearing_next;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;
    node_entry_t      rd_q_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             lw_valid_reg;
    logic             lw_valid_next;
    logic [IDX_W-1:0] lw_addr_reg;
    node_entry_t      lw_data_reg;

    // Clearing sweep, one entry per cycle.
    assign clearing_next = clearing_reg && (clr_addr_reg != LAST_ADDR);
    assign clr_addr_next = clearing_reg ? clr_addr_reg + 1'b1 : clr_addr_reg;
    assign lw_valid_next = lw_valid_reg || wr_en;
    assign clear_done    = !clearing_reg;

    // The read samples the old contents when a write hits the same entry in
    // the same cycle; the last write is kept aside to cover that case.
    assign rd_data = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg : rd_q_reg;

    // Memory array and read data register.
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg    <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            lw_addr_reg <= wr_addr;
            lw_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            lw_valid_reg <= lw_valid_next;
        end
    end

    `ASSERT_IMP(a_no_read_in_clear, clk, rst_n, clearing_reg, !rd_en, "read during clear")
    `ASSERT_IMP(a_no_write_in_clear, clk, rst_n, clearing_reg, !wr_en, "write during clear")
    `ASSERT_IMP(a_clear_wraps, clk, rst_n, $fell(clearing_reg), clr_addr_reg == '0, "clear cut short")

endmodule

@@ sv/vhmnn_scan.sv @@
// ============================================================================
// vhmnn_scan
// Voxel scan control: tracks the raster position, takes voxel words and
// steps through the eight corners of a filled voxel, forming each corner's
// node table index and its scaled coordinates.
// ============================================================================
module vhmnn_scan import vhmnn_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    input  restart_t       restart,
    input  logic           clear_done,
    vhmnn_in_if.sink       voxels,
    output issue_t         issue,
    input  logic           take
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BASE  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;

    logic [1:0]           state_reg,  state_next;
    logic [POS_W-1:0]     pos_x_reg,  pos_x_next;
    logic [POS_W-1:0]     pos_y_reg,  pos_y_next;
    logic [POS_W-1:0]     pos_z_reg,  pos_z_next;
    logic                 done_reg,   done_next;
    logic [CORNER_W-1:0]  corner_reg, corner_next;
    logic [POS_W-1:0]     cell_x_reg, cell_x_next;
    logic [POS_W-1:0]     cell_y_reg, cell_y_next;
    logic [POS_W-1:0]     cell_z_reg, cell_z_next;
    logic [MAT_W-1:0]     mat_reg,    mat_next;
    logic [RAW_IDX_W-1:0] base_reg,   base_next;
    logic [PLANE_W-1:0]   plane_reg,  plane_next;

    logic [GRID_W-1:0]    slab_sum;
    logic [GRID_W-1:0]    slab_end;
    logic [GRID_W-1:0]    nzn;
    logic [GRID_W-1:0]    nyn;
    logic [POS_W-1:0]     z_inc;
    logic [POS_W-1:0]     y_inc;
    logic [POS_W-1:0]     x_inc;
    logic                 accept;
    logic                 in_slab;
    logic                 ox;
    logic                 oy;
    logic                 oz;
    logic [GRID_W-1:0]    gx;
    logic [GRID_W-1:0]    gy;
    logic [GRID_W-1:0]    gz;

    // Slab end is the smaller of x_start + x_count and dim_x.
    assign slab_sum = GRID_W'(cfg.x_start) + GRID_W'(cfg.x_count);
    assign slab_end = (slab_sum > GRID_W'(cfg.dim_x)) ? GRID_W'(cfg.dim_x) : slab_sum;
    assign nzn      = GRID_W'(cfg.dim_z) + 1'b1;
    assign nyn      = GRID_W'(cfg.dim_y) + 1'b1;
    assign z_inc    = pos_z_reg + 1'b1;
    assign y_inc    = pos_y_reg + 1'b1;
    assign x_inc    = pos_x_reg + 1'b1;
    assign in_slab  = GRID_W'(pos_x_reg) < slab_end;

    assign voxels.ready = (state_reg == ST_IDLE) && clear_done;
    assign accept       = voxels.valid && voxels.ready;

    // Nodes per x plane follows the y and z dimensions.
    assign plane_next = PLANE_W'(PLANE_W'(nzn) * PLANE_W'(nyn));

    // Sequencer and raster position.
    always_comb
    begin
        state_next  = state_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        pos_z_next  = pos_z_reg;
        done_next   = done_reg;
        corner_next = corner_reg;
        cell_x_next = cell_x_reg;
        cell_y_next = cell_y_reg;
        cell_z_next = cell_z_reg;
        mat_next    = mat_reg;
        base_next   = base_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && !done_reg)
                begin
                    if (!in_slab)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (voxels.voxel_material != '0)
                        begin
                            cell_x_next = pos_x_reg;
                            cell_y_next = pos_y_reg;
                            cell_z_next = pos_z_reg;
                            mat_next    = voxels.voxel_material;
                            state_next  = ST_BASE;
                        end
                        // Advance z, then y, then x.
                        pos_z_next = z_inc;
                        if (z_inc >= cfg.dim_z)
                        begin
                            pos_z_next = '0;
                            pos_y_next = y_inc;
                            if (y_inc >= cfg.dim_y)
                            begin
                                pos_y_next = '0;
                                pos_x_next = x_inc;
                                if (GRID_W'(x_inc) >= slab_end)
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_BASE:
            begin
                base_next = RAW_IDX_W'(cell_x_reg) * RAW_IDX_W'(plane_reg)
                          + RAW_IDX_W'(cell_y_reg) * RAW_IDX_W'(nzn)
                          + RAW_IDX_W'(cell_z_reg);
                corner_next = '0;
                state_next  = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (take)
                begin
                    corner_next = corner_reg + 1'b1;
                    if (corner_reg == LAST_CORNER)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (restart.valid)
        begin
            pos_x_next = restart.x_start;
            pos_y_next = '0;
            pos_z_next = '0;
            done_next  = 1'b0;
        end
    end

    // Corner index and scaled coordinates for the corner being issued.
    assign ox = OFF_X_MASK[corner_reg];
    assign oy = OFF_Y_MASK[corner_reg];
    assign oz = OFF_Z_MASK[corner_reg];
    assign gx = GRID_W'(cell_x_reg) + GRID_W'(ox);
    assign gy = GRID_W'(cell_y_reg) + GRID_W'(oy);
    assign gz = GRID_W'(cell_z_reg) + GRID_W'(oz);

    always_comb
    begin
        issue.valid        = (state_reg == ST_ISSUE);
        issue.req.raw_idx  = base_reg
                           + (ox ? RAW_IDX_W'(plane_reg) : '0)
                           + (oy ? RAW_IDX_W'(nzn) : '0)
                           + RAW_IDX_W'(oz);
        issue.req.corner   = corner_reg;
        issue.req.material = mat_reg;
        issue.req.prod_x   = PROD_W'(gx) * PROD_W'(cfg.spacing_x);
        issue.req.prod_y   = PROD_W'(gy) * PROD_W'(cfg.spacing_y);
        issue.req.prod_z   = PROD_W'(gz) * PROD_W'(cfg.spacing_z);
    end

    always_ff @(posedge clk)
    begin
        cell_x_reg <= cell_x_next;
        cell_y_reg <= cell_y_next;
        cell_z_reg <= cell_z_next;
        mat_reg    <= mat_next;
        base_reg   <= base_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_x_reg  <= X_START_RESET;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            done_reg   <= 1'b0;
            corner_reg <= '0;
            plane_reg  <= PLANE_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            pos_z_reg  <= pos_z_next;
            done_reg   <= done_next;
            corner_reg <= corner_next;
            plane_reg  <= plane_next;
        end
    end

endmodule

@@ sv/vhmnn_emit.sv @@
// ============================================================================
// vhmnn_emit
// Lookup and emit stage: issues node table reads, resolves each corner as a
// known node or a new one, hands out dense ids, writes new entries back and
// holds the output word.
// ============================================================================
`include "assert_macros.svh"

module vhmnn_emit import vhmnn_pkg::*; (
    input  logic                          clk,
    input  logic                          rst_n,
    input  issue_t                        issue,
    output logic                          take,
    output logic                          rd_en,
    output logic [$clog2(NODE_DEPTH)-1:0] rd_addr,
    input  node_entry_t                   rd_data,
    output logic                          wr_en,
    output logic [$clog2(NODE_DEPTH)-1:0] wr_addr,
    output node_entry_t                   wr_data,
    vhmnn_out_if.source                   corners
);

    localparam int IDX_W = $clog2(NODE_DEPTH);
    localparam int EXT_W = (IDX_W > RAW_IDX_W) ? IDX_W : RAW_IDX_W;

    logic                s1_valid_reg,  s1_valid_next;
    corner_req_t         s1_req_reg,    s1_req_next;
    logic [ID_W-1:0]     next_id_reg,   next_id_next;
    logic                out_valid_reg, out_valid_next;
    logic [CORNER_W-1:0] out_corner_reg,  out_corner_next;
    logic [ID_W-1:0]     out_id_reg,      out_id_next;
    logic                out_new_reg,     out_new_next;
    logic [COORD_W-1:0]  out_coord_x_reg, out_coord_x_next;
    logic [COORD_W-1:0]  out_coord_y_reg, out_coord_y_next;
    logic [COORD_W-1:0]  out_coord_z_reg, out_coord_z_next;
    logic [MAT_W-1:0]    out_mat_reg,     out_mat_next;
    logic                out_last_reg,    out_last_next;

    logic                advance;
    logic                fresh;
    logic [EXT_W-1:0]    rd_ext;
    logic [EXT_W-1:0]    wr_ext;

    // Products above the Q22.16 range clip to full scale.
    function automatic logic [COORD_W-1:0] sat_coord(input logic [PROD_W-1:0] p);
        sat_coord = (|p[PROD_W-1:COORD_W]) ? '1 : p[COORD_W-1:0];
    endfunction

    // Pipeline handshake: the lookup stage moves when the output word is free.
    assign advance = s1_valid_reg && (!out_valid_reg || corners.ready);
    assign take    = !s1_valid_reg || advance;

    // Node index wraps at the table depth.
    assign rd_ext  = EXT_W'(issue.req.raw_idx);
    assign wr_ext  = EXT_W'(s1_req_reg.raw_idx);
    assign rd_en   = issue.valid && take;
    assign rd_addr = rd_ext[IDX_W-1:0];
    assign wr_addr = wr_ext[IDX_W-1:0];

    // A node not yet in the table takes the next dense id.
    assign fresh         = !rd_data.valid;
    assign wr_en         = advance && fresh;
    assign wr_data.valid = 1'b1;
    assign wr_data.id    = next_id_reg;
    assign next_id_next  = wr_en ? next_id_reg + 1'b1 : next_id_reg;

    assign s1_valid_next = take ? issue.valid : s1_valid_reg;
    assign s1_req_next   = rd_en ? issue.req : s1_req_reg;

    // Output word.
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_corner_next  = out_corner_reg;
        out_id_next      = out_id_reg;
        out_new_next     = out_new_reg;
        out_coord_x_next = out_coord_x_reg;
        out_coord_y_next = out_coord_y_reg;
        out_coord_z_next = out_coord_z_reg;
        out_mat_next     = out_mat_reg;
        out_last_next    = out_last_reg;
        if (advance)
        begin
            out_valid_next   = 1'b1;
            out_corner_next  = s1_req_reg.corner;
            out_id_next      = fresh ? next_id_reg : rd_data.id;
            out_new_next     = fresh;
            out_coord_x_next = fresh ? sat_coord(s1_req_reg.prod_x) : '0;
            out_coord_y_next = fresh ? sat_coord(s1_req_reg.prod_y) : '0;
            out_coord_z_next = fresh ? sat_coord(s1_req_reg.prod_z) : '0;
            out_mat_next     = s1_req_reg.material;
            out_last_next    = (s1_req_reg.corner == LAST_CORNER);
        end
        else if (corners.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign corners.valid         = out_valid_reg;
    assign corners.corner        = out_corner_reg;
    assign corners.node_id       = out_id_reg;
    assign corners.node_new      = out_new_reg;
    assign corners.coord_x       = out_coord_x_reg;
    assign corners.coord_y       = out_coord_y_reg;
    assign corners.coord_z       = out_coord_z_reg;
    assign corners.cell_material = out_mat_reg;
    assign corners.cell_last     = out_last_reg;

    always_ff @(posedge clk)
    begin
        s1_req_reg      <= s1_req_next;
        out_corner_reg  <= out_corner_next;
        out_id_reg      <= out_id_next;
        out_new_reg     <= out_new_next;
        out_coord_x_reg <= out_coord_x_next;
        out_coord_y_reg <= out_coord_y_next;
        out_coord_z_reg <= out_coord_z_next;
        out_mat_reg     <= out_mat_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEXT(a_id_step, clk, rst_n, advance && fresh, next_id_reg == ID_W'($past(next_id_reg) + 1'b1), "id not advanced for new node")
    `ASSERT_NEXT(a_id_hold, clk, rst_n, advance && !fresh, $stable(next_id_reg), "id advanced for known node")
    `ASSERT_IMP(a_old_zero, clk, rst_n, out_valid_reg && !out_new_reg, out_coord_x_reg == '0 && out_coord_y_reg == '0 && out_coord_z_reg == '0, "coordinates on known node")

endmodule

@@ sv/voxel_hex_mesh_node_numbering.sv @@
// ============================================================================
// voxel_hex_mesh_node_numbering
// Numbers the nodes of a hexahedral mesh built from a voxel slab.
//
//   Channel   Dir   Handshake            Word
//   voxels    in    valid/ready          voxel_material
//   corners   out   valid/ready          corner, node_id, node_new, coords,
//                                        cell_material, cell_last
//   APB       in    psel/penable/pready  8 registers at byte address 4*i
//
// An empty voxel, or one past the slab end, is taken without issuing any corner.
// A filled voxel is accepted, then its base index is formed, then its eight
// corners are looked up through the single read port of the node table.
// After reset every entry of the node table is swept clear; no voxel is taken
// until then, register writes are taken as ever.
// A stalled corners channel holds the lookup pipeline and the corner sequencer in place.
// ============================================================================
module voxel_hex_mesh_node_numbering import vhmnn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    vhmnn_in_if.sink              voxels,
    vhmnn_out_if.source           corners
);

    localparam int IDX_W = $clog2(NODE_DEPTH);

    cfg_t             cfg;
    restart_t         restart;
    issue_t           issue;
    logic             take;
    logic             clear_done;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    node_entry_t      rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    node_entry_t      wr_data;

    // Register file.
    vhmnn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // Node table memory.
    vhmnn_node_table u_node_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .clear_done (clear_done)
    );

    // Raster scan and corner sequencer.
    vhmnn_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .restart    (restart),
        .clear_done (clear_done),
        .voxels     (voxels),
        .issue      (issue),
        .take       (take)
    );

    // Lookup, id allocation and output word.
    vhmnn_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (issue),
        .take    (take),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .corners (corners)
    );

endmodule
